FILE: rtl/char_lcd_bus_sequencer_assert.svh
// Assertion macros for the character-LCD bus sequencer.
// Uses clk_i and rst_ni from the scope of the module that includes it.
`ifndef CHAR_LCD_BUS_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_BUS_SEQUENCER_ASSERT_SVH

// Clocked assertion, off while reset is held.
`define CLBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, with the implication written out.
`define CLBS_ASSERT_IMP(label, cond, prop, msg) \
  `CLBS_ASSERT(label, (cond) |=> (prop), msg)

`endif

FILE: rtl/clbs_pkg.sv
// Shared types, constants and the init strobe table of the LCD bus sequencer.
// No dependencies.
`timescale 1ns / 1ps
package clbs_pkg;

  localparam int unsigned StepW = 4;

  typedef enum logic [1:0] {
    OpCmd    = 2'd0,
    OpData   = 2'd1,
    OpCursor = 2'd2,
    OpInit   = 2'd3
  } opcode_e;

  localparam logic [7:0]  DdramSet    = 8'h80;
  localparam logic [11:0] NibbleGapUs = 12'd1;
  localparam logic [11:0] CmdWaitUs   = 12'd50;
  localparam logic [11:0] NibCmdWaitUs = 12'd51;
  localparam logic [15:0] PowerupUs   = 16'd40000;
  localparam logic [StepW-1:0] FirstStep = '0;

  // Decoded request handed from front to back.
  typedef struct packed {
    logic       is_init;
    logic       nib;      // four-bit bus
    logic       rs;
    logic [7:0] data;
  } job_t;

  // One enable strobe.
  typedef struct packed {
    logic        rs;
    logic [7:0]  bus;
    logic [15:0] before_us;
    logic [11:0] after_us;
    logic        last;
  } strobe_t;

  function automatic logic [7:0] row_base(logic [1:0] row);
    logic [7:0] b;
    b = 8'h00;
    unique case (row)
      2'd0: b = 8'h00;
      2'd1: b = 8'h40;
      2'd2: b = 8'h14;
      2'd3: b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic strobe_t mk(logic [7:0] bus, logic [11:0] after_us, logic last);
    strobe_t s;
    s.rs        = 1'b0;
    s.bus       = bus;
    s.before_us = 16'd0;
    s.after_us  = after_us;
    s.last      = last;
    return s;
  endfunction

  // Power-up init sequence, one strobe per step.
  function automatic strobe_t init_strobe(logic nib, logic [StepW-1:0] step);
    strobe_t s;
    s = mk(8'h00, 12'd0, 1'b0);
    if (nib) begin
      unique case (step)
        4'd0:  s = mk(8'h30, 12'd4001, 1'b0);
        4'd1:  s = mk(8'h30, 12'd101, 1'b0);
        4'd2:  s = mk(8'h30, 12'd51, 1'b0);
        4'd3:  s = mk(8'h20, 12'd51, 1'b0);
        4'd4:  s = mk(8'h20, 12'd1, 1'b0);
        4'd5:  s = mk(8'h80, 12'd51, 1'b0);
        4'd6:  s = mk(8'h00, 12'd1, 1'b0);
        4'd7:  s = mk(8'h80, 12'd51, 1'b0);
        4'd8:  s = mk(8'h00, 12'd1, 1'b0);
        4'd9:  s = mk(8'h10, 12'd2051, 1'b0);
        4'd10: s = mk(8'h00, 12'd1, 1'b0);
        4'd11: s = mk(8'h60, 12'd51, 1'b0);
        4'd12: s = mk(8'h00, 12'd1, 1'b0);
        4'd13: s = mk(8'hC0, 12'd51, 1'b1);
        default: s = mk(8'h00, 12'd0, 1'b1);
      endcase
    end else begin
      unique case (step)
        4'd0: s = mk(8'h30, 12'd4050, 1'b0);
        4'd1: s = mk(8'h30, 12'd150, 1'b0);
        4'd2: s = mk(8'h30, 12'd50, 1'b0);
        4'd3: s = mk(8'h38, 12'd50, 1'b0);
        4'd4: s = mk(8'h08, 12'd50, 1'b0);
        4'd5: s = mk(8'h01, 12'd2050, 1'b0);
        4'd6: s = mk(8'h06, 12'd50, 1'b0);
        4'd7: s = mk(8'h0C, 12'd50, 1'b1);
        default: s = mk(8'h00, 12'd0, 1'b1);
      endcase
    end
    if (step == FirstStep) begin
      s.before_us = PowerupUs;
    end
    return s;
  endfunction

endpackage

FILE: rtl/clbs_front.sv
// Front end: takes requests, decodes them into jobs, holds them in a 2-deep queue.
// Depends on clbs_pkg.
`timescale 1ns / 1ps
module clbs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic [1:0]      opcode_i,
  input  logic [7:0]      value_i,
  input  logic [5:0]      column_i,
  input  logic [2:0]      row_i,
  input  logic            nib_i,
  output logic            job_valid_o,
  output clbs_pkg::job_t  job_o,
  input  logic            job_pop_i
);
  import clbs_pkg::*;

  job_t       q_mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  job_t       job_new;
  logic [1:0] row_eff;
  logic [7:0] addr;
  logic       wr, rd;

  // row above three falls back to row 0
  assign row_eff = row_i[2] ? 2'd0 : row_i[1:0];
  assign addr    = DdramSet | (8'({2'b00, column_i}) + row_base(row_eff));

  always_comb begin
    job_new.is_init = 1'b0;
    job_new.nib     = nib_i;
    job_new.rs      = 1'b0;
    job_new.data    = value_i;
    unique case (opcode_e'(opcode_i))
      OpCmd:    job_new.data = value_i;
      OpData:   job_new.rs   = 1'b1;
      OpCursor: job_new.data = addr;
      OpInit:   job_new.is_init = 1'b1;
      default:  job_new.is_init = 1'b0;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign wr          = push_i && !full_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign rd          = job_pop_i && job_valid_o;
  assign job_o       = q_mem[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      q_mem[wp_q] <= job_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/clbs_back.sv
// Back end: walks each job through its strobes, one strobe per cycle while the output has space.
// Depends on clbs_pkg and the assertion macro header.
`timescale 1ns / 1ps
module clbs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  clbs_pkg::job_t    job_i,
  output logic              job_pop_o,
  input  logic              out_space_i,
  output logic              strobe_valid_o,
  output clbs_pkg::strobe_t strobe_o
);
  import clbs_pkg::*;
  `include "char_lcd_bus_sequencer_assert.svh"

  logic [StepW-1:0] step_q, step_d;
  strobe_t          byte_s;
  logic             emit;

  // Byte transfer: one strobe on an eight-bit bus, high then low nibble on four.
  always_comb begin
    byte_s.rs        = job_i.rs;
    byte_s.before_us = 16'd0;
    if (job_i.nib) begin
      if (step_q == FirstStep) begin
        byte_s.bus      = {job_i.data[7:4], 4'h0};
        byte_s.after_us = NibbleGapUs;
        byte_s.last     = 1'b0;
      end else begin
        byte_s.bus      = {job_i.data[3:0], 4'h0};
        byte_s.after_us = NibCmdWaitUs;
        byte_s.last     = 1'b1;
      end
    end else begin
      byte_s.bus      = job_i.data;
      byte_s.after_us = CmdWaitUs;
      byte_s.last     = 1'b1;
    end
  end

  assign strobe_o       = job_i.is_init ? init_strobe(job_i.nib, step_q) : byte_s;
  assign emit           = job_valid_i && out_space_i;
  assign strobe_valid_o = emit;
  assign job_pop_o      = emit && strobe_o.last;

  always_comb begin
    step_d = step_q;
    if (emit) begin
      step_d = strobe_o.last ? FirstStep : step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= FirstStep;
    end else begin
      step_q <= step_d;
    end
  end

  `CLBS_ASSERT(a_step_range, step_q <= 4'd13, "strobe step past end of init sequence")
  `CLBS_ASSERT_IMP(a_step_clr, emit && strobe_o.last,
                   step_q == FirstStep, "step not cleared after last strobe")
  `CLBS_ASSERT_IMP(a_step_inc, emit && !strobe_o.last,
                   step_q == $past(step_q) + 4'd1, "step did not advance")
  `CLBS_ASSERT(a_byte8_one, job_valid_i && !job_i.is_init && !job_i.nib |->
               step_q == FirstStep, "eight-bit byte job mid-sequence")

endmodule

FILE: rtl/clbs_outq.sv
// Result queue: two-entry FIFO of strobes in front of the output ports.
// Depends on clbs_pkg.
`timescale 1ns / 1ps
module clbs_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  clbs_pkg::strobe_t wdata_i,
  output logic              full_o,
  output logic              empty_o,
  input  logic              rd_i,
  output clbs_pkg::strobe_t rdata_o
);
  import clbs_pkg::*;

  strobe_t    mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  logic       rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rd      = rd_i && !empty_o;
  assign rdata_o = mem[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd && !wr_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd)   rp_q <= ~rp_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/char_lcd_bus_sequencer.sv
// Character-LCD bus sequencer. Each request (command byte, data byte, set
// cursor, power-up init) becomes a run of enable strobes; every strobe pops out
// as one item carrying RS, the bus value, the wait before enable rises and the
// wait after it falls, with last marking the final strobe of the request.
// Rate: one strobe per clock while the result queue has room or is popped; a
// request yields as many strobes as it needs - 1 for a byte on the eight-bit
// bus, 2 on the four-bit bus, 8 or 14 for init - as set by the strobe sequencer
// in the back end. A 2-deep job queue in front and a 2-deep result queue behind
// let requests be taken back to back while earlier strobes are still pending.
// bus_mode (APB offset 0x0, reset 1 = four-bit) is sampled when a request is
// accepted; change it only with the block idle. No clearing pass after reset.
// Depends on clbs_pkg, clbs_front, clbs_back and clbs_outq.
`timescale 1ns / 1ps
module char_lcd_bus_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  value_i,
  input  logic [5:0]  column_i,
  input  logic [2:0]  row_i,
  // strobe side
  output logic        empty,
  input  logic        pop,
  output logic        reg_select_o,
  output logic [7:0]  bus_value_o,
  output logic [15:0] wait_before_us_o,
  output logic [11:0] wait_after_us_o,
  output logic        last_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import clbs_pkg::*;

  logic    bus_mode_q;
  logic    reg_hit;
  logic    job_valid, job_pop;
  job_t    job;
  logic    strobe_valid, outq_full, out_space;
  strobe_t strobe, head;

  // Only offset 0x0 holds a register; 0x4 and up read zero, ignore writes.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);
  assign prdata  = reg_hit ? {31'd0, bus_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_mode_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      bus_mode_q <= pwdata[0];
    end
  end

  clbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .nib_i       (bus_mode_q),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  // A pop this cycle frees a slot for the next strobe.
  assign out_space = !outq_full || pop;

  clbs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .job_pop_o      (job_pop),
    .out_space_i    (out_space),
    .strobe_valid_o (strobe_valid),
    .strobe_o       (strobe)
  );

  clbs_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (strobe_valid),
    .wdata_i (strobe),
    .full_o  (outq_full),
    .empty_o (empty),
    .rd_i    (pop),
    .rdata_o (head)
  );

  assign reg_select_o     = head.rs;
  assign bus_value_o      = head.bus;
  assign wait_before_us_o = head.before_us;
  assign wait_after_us_o  = head.after_us;
  assign last_o           = head.last;

endmodule
